[hdl/go_back_n_packet_receiver_top_assert.svh]
// Assertion macros for the go-back-N receiver.
// Included by the top level; no other dependencies.
`ifndef GO_BACK_N_PACKET_RECEIVER_TOP_ASSERT_SVH
`define GO_BACK_N_PACKET_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define GBNR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GBNR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GBNR_ASSERT_NOW(label, ante, cons)
`define GBNR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/gbnr_pkg.sv]
// Shared types, codes and helpers for the go-back-N receiver.
// No dependencies.
package gbnr_pkg;

    localparam logic [15:0] FLAG_START      = 16'h0010;
    localparam logic [15:0] FLAG_OVER       = 16'h0008;
    localparam logic [15:0] FLAG_ABORT      = 16'h0018;
    localparam logic [15:0] FLAG_ACK        = 16'h0002;
    localparam logic [15:0] SUM_GOOD        = 16'hffff;

    typedef enum logic [2:0] {
        OC_START  = 3'd0,
        OC_DATA   = 3'd1,
        OC_LAST   = 3'd2,
        OC_REJECT = 3'd3,
        OC_QUIT   = 3'd4
    } outcome_t;

    // Packet class decided by the front end
    typedef enum logic [2:0] {
        CLS_REJECT,
        CLS_QUIT,
        CLS_START,
        CLS_DATA,
        CLS_OVER
    } pkt_cls_t;

    typedef struct packed {
        pkt_cls_t     cls;
        logic [15:0]  seq;
        logic [10:0]  pay;
    } pkt_rec_t;

    // Ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

[hdl/go_back_n_packet_receiver_top.sv]
// Top level of the go-back-N packet receiver: front end, packet queue, back end.
// Depends on gbnr_pkg, gbnr_front, gbnr_fifo, gbnr_back and the assert header.
//
// Channel | handshake                   | payload
// input   | word_valid / word_ready     | word, last_word
// result  | result_valid / result_ready | outcome, ack_req, ack_seq, ack_stream_seq,
//         |                             | ack_checksum, payload_bytes
//
// One word per cycle is taken while the packet queue has room; a packet's result
// passes through a queue entry and is then held in the back end's output register.
// A two-entry packet queue sits between the word front end and the window logic;
// input stalls only when that queue is full behind a stalled result.
// Reset clears control state, not queue storage or result fields. After an abort packet words are taken and dropped.
`include "go_back_n_packet_receiver_top_assert.svh"
module go_back_n_packet_receiver_top import gbnr_pkg::*; #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_ready,
    input  logic [15:0] word,
    input  logic        last_word,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  outcome,
    output logic        ack_req,
    output logic [15:0] ack_seq,
    output logic [15:0] ack_stream_seq,
    output logic [15:0] ack_checksum,
    output logic [10:0] payload_bytes
);

    logic     q_push, q_full, q_not_empty, q_pop;
    pkt_rec_t q_in, q_out;

    gbnr_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word),
        .last_word  (last_word),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    gbnr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    gbnr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .outcome        (outcome),
        .ack_req        (ack_req),
        .ack_seq        (ack_seq),
        .ack_stream_seq (ack_stream_seq),
        .ack_checksum   (ack_checksum),
        .payload_bytes  (payload_bytes)
    );

    `GBNR_ASSERT_NOW(a_no_ack_only_quit, result_valid && !ack_req, outcome == OC_QUIT)
    `GBNR_ASSERT_NOW(a_reject_no_payload, result_valid && outcome == OC_REJECT, payload_bytes == 11'd0)
    `GBNR_ASSERT_NEXT(a_quit_is_final, result_valid && result_ready && outcome == OC_QUIT, !result_valid)
    `GBNR_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full)

endmodule

[hdl/gbnr_front.sv]
// Front end: accepts packet words, keeps the running sum and header fields,
// classifies each packet on its last word. Depends on gbnr_pkg.
module gbnr_front import gbnr_pkg::*; #(
    parameter int BUFFER_BYTES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        word_valid,
    output logic        word_ready,
    input  logic [15:0] word,
    input  logic        last_word,
    input  logic        q_full,
    output logic        q_push,
    output pkt_rec_t    q_data
);

    localparam logic [15:0] BufMax = 16'(BUFFER_BYTES);

    logic [15:0] sum_reg, sum_next;
    logic [2:0]  idx_reg, idx_next;       // saturates at 5
    logic [10:0] size_reg, size_next;
    logic [15:0] flag_reg, flag_next;
    logic [15:0] seq_reg, seq_next;
    logic        quit_reg, quit_next;
    logic        acc;
    logic [10:0] clamp_w;
    pkt_cls_t    cls;

    assign word_ready = quit_reg || !q_full;
    assign acc        = word_valid && word_ready;

    assign clamp_w = (word > BufMax) ? BufMax[10:0] : word[10:0];

    always_comb
    begin
        sum_next  = oc_add(sum_reg, word);
        size_next = (idx_reg == 3'd0) ? clamp_w : size_reg;
        flag_next = (idx_reg == 3'd2) ? word : flag_reg;
        seq_next  = (idx_reg == 3'd4) ? word : seq_reg;
        idx_next  = (idx_reg < 3'd5) ? idx_reg + 3'd1 : idx_reg;

        if (idx_reg < 3'd4)
            cls = CLS_REJECT;
        else if (flag_next == FLAG_ABORT)
            cls = CLS_QUIT;
        else if (sum_next != SUM_GOOD)
            cls = CLS_REJECT;
        else if (flag_next == FLAG_START)
            cls = CLS_START;
        else if (flag_next == FLAG_OVER)
            cls = CLS_OVER;
        else
            cls = CLS_DATA;

        quit_next = quit_reg || (q_push && cls == CLS_QUIT);
    end

    assign q_push     = acc && last_word && !quit_reg;
    assign q_data.cls = cls;
    assign q_data.seq = seq_next;
    assign q_data.pay = size_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            idx_reg  <= '0;
            size_reg <= '0;
            flag_reg <= '0;
            seq_reg  <= '0;
            quit_reg <= 1'b0;
        end
        else if (acc)
        begin
            quit_reg <= quit_next;
            if (last_word)
            begin
                sum_reg  <= '0;
                idx_reg  <= '0;
                size_reg <= '0;
                flag_reg <= '0;
                seq_reg  <= '0;
            end
            else if (!quit_reg)
            begin
                sum_reg  <= sum_next;
                idx_reg  <= idx_next;
                size_reg <= size_next;
                flag_reg <= flag_next;
                seq_reg  <= seq_next;
            end
        end
    end

endmodule

[hdl/gbnr_fifo.sv]
// Two-entry queue of classified packets between front and back ends.
// Depends on gbnr_pkg.
module gbnr_fifo import gbnr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pkt_rec_t push_data,
    output logic     full,
    output logic     not_empty,
    input  logic     pop,
    output pkt_rec_t pop_data
);

    localparam int Depth = 2;

    pkt_rec_t mem [Depth];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'(Depth));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[hdl/gbnr_back.sv]
// Back end: applies the go-back-N window to classified packets, updates the
// expected sequence and stream count, and registers the result. Uses gbnr_pkg.
module gbnr_back import gbnr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  pkt_rec_t    q_data,
    output logic        q_pop,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  outcome,
    output logic        ack_req,
    output logic [15:0] ack_seq,
    output logic [15:0] ack_stream_seq,
    output logic [15:0] ack_checksum,
    output logic [10:0] payload_bytes
);

    logic [15:0] exp_reg, exp_next;
    logic [15:0] stream_reg, stream_next;
    logic        valid_reg;
    outcome_t    oc_reg, oc_c;
    logic        ack_reg, ack_c;
    logic [15:0] aseq_reg, aseq_c;
    logic [15:0] astr_reg, astr_c;
    logic [15:0] ack_ck_reg, ack_ck_c;
    logic [10:0] pay_reg, pay_c;
    logic [15:0] exp_inc;

    assign q_pop   = q_not_empty && (!valid_reg || result_ready);
    assign exp_inc = exp_reg + 16'd1;

    always_comb
    begin
        exp_next    = exp_reg;
        stream_next = stream_reg;
        oc_c        = OC_REJECT;
        ack_c       = 1'b1;
        pay_c       = '0;
        case (q_data.cls)
            CLS_QUIT:
            begin
                oc_c        = OC_QUIT;
                ack_c       = 1'b0;
                stream_next = stream_reg + 16'd1;
                exp_next    = '0;
            end
            CLS_START:
            begin
                if (q_data.seq == exp_reg)
                begin
                    oc_c  = OC_START;
                    pay_c = q_data.pay;
                end
            end
            CLS_DATA, CLS_OVER:
            begin
                if (q_data.seq == exp_inc)
                begin
                    exp_next = exp_inc;
                    pay_c    = q_data.pay;
                    oc_c     = (q_data.cls == CLS_OVER) ? OC_LAST : OC_DATA;
                end
            end
            default:
            begin
                oc_c = OC_REJECT;
            end
        endcase

        // ack carries the sequence after advance and the stream before the bump
        aseq_c   = ack_c ? exp_next : 16'd0;
        astr_c   = ack_c ? stream_reg : 16'd0;
        ack_ck_c = ack_c ? ~oc_add(oc_add(FLAG_ACK, stream_reg), exp_next) : 16'd0;

        // end of file: bump stream and restart sequence
        if (oc_c == OC_LAST)
        begin
            stream_next = stream_reg + 16'd1;
            exp_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg    <= '0;
            stream_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                exp_reg    <= exp_next;
                stream_reg <= stream_next;
                valid_reg  <= 1'b1;
            end
            else if (result_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            oc_reg     <= oc_c;
            ack_reg    <= ack_c;
            aseq_reg   <= aseq_c;
            astr_reg   <= astr_c;
            ack_ck_reg <= ack_ck_c;
            pay_reg    <= pay_c;
        end
    end

    assign result_valid   = valid_reg;
    assign outcome        = oc_reg;
    assign ack_req        = ack_reg;
    assign ack_seq        = aseq_reg;
    assign ack_stream_seq = astr_reg;
    assign ack_checksum   = ack_ck_reg;
    assign payload_bytes  = pay_reg;

endmodule
